// File: sv/bsfe_pkg.sv
// ----------------------------------------------------------------------------
// bsfe_pkg
// shared types and constants for the byte stuffed frame encoder
// ----------------------------------------------------------------------------
`default_nettype none

package bsfe_pkg;

    // item operation codes
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_DATA  = 2'd1;
    localparam logic [1:0] OP_END   = 2'd2;

    // line bytes with special meaning
    localparam logic [7:0] BYTE_START = 8'h42;
    localparam logic [7:0] BYTE_END   = 8'h69;
    localparam logic [7:0] BYTE_ESC   = 8'h7B;

    // escape codes following BYTE_ESC
    localparam logic [7:0] ESC_CODE_START = 8'd1;
    localparam logic [7:0] ESC_CODE_ESC   = 8'd2;
    localparam logic [7:0] ESC_CODE_END   = 8'd3;

    // default depth of the command queue between front and back
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] frame_kind;
        logic [7:0] sequence_number;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] line_byte;
        logic       run_last;
        logic       frame_done;
    } t_out_item;

    // one classified transaction: up to three line bytes
    typedef struct packed {
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [7:0] byte2;
        logic [1:0] last_idx;
        logic       is_end;
    } t_cmd;

endpackage

`default_nettype wire

// File: sv/bsfe_front.sv
// ----------------------------------------------------------------------------
// bsfe_front
// classifies input transactions, tracks frame state and checksum
// ----------------------------------------------------------------------------
`default_nettype none

module bsfe_front (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_ready,
    input  bsfe_pkg::t_in_item i_in_data,
    input  wire               i_queue_full,
    output logic              o_push,
    output bsfe_pkg::t_cmd    o_cmd
);

    logic [7:0] r_sum;
    logic       r_inside;
    logic [7:0] n_sum;
    logic       n_inside;
    logic       keep;
    logic [7:0] esc_code;
    logic       accept;

    assign o_in_ready = !i_queue_full;
    assign accept     = i_in_valid && !i_queue_full;
    assign o_push     = accept && keep;

    always_comb begin
        priority if (i_in_data.data_byte == bsfe_pkg::BYTE_START) begin
            esc_code = bsfe_pkg::ESC_CODE_START;
        end else if (i_in_data.data_byte == bsfe_pkg::BYTE_ESC) begin
            esc_code = bsfe_pkg::ESC_CODE_ESC;
        end else if (i_in_data.data_byte == bsfe_pkg::BYTE_END) begin
            esc_code = bsfe_pkg::ESC_CODE_END;
        end else begin
            esc_code = 8'd0;
        end
    end

    always_comb begin
        keep     = 1'b0;
        n_sum    = r_sum;
        n_inside = r_inside;
        o_cmd    = '0;
        unique case (i_in_data.op)
            bsfe_pkg::OP_START: begin
                keep           = 1'b1;
                o_cmd.byte0    = bsfe_pkg::BYTE_START;
                o_cmd.byte1    = i_in_data.frame_kind;
                o_cmd.byte2    = i_in_data.sequence_number;
                o_cmd.last_idx = 2'd2;
                n_sum          = i_in_data.frame_kind + i_in_data.sequence_number;
                n_inside       = 1'b1;
            end
            bsfe_pkg::OP_DATA: begin
                keep = r_inside;
                if (esc_code == 8'd0) begin
                    o_cmd.byte0    = i_in_data.data_byte;
                    o_cmd.last_idx = 2'd0;
                    n_sum          = r_sum + i_in_data.data_byte;
                end else begin
                    o_cmd.byte0    = bsfe_pkg::BYTE_ESC;
                    o_cmd.byte1    = esc_code;
                    o_cmd.last_idx = 2'd1;
                    n_sum          = r_sum + bsfe_pkg::BYTE_ESC + esc_code;
                end
            end
            bsfe_pkg::OP_END: begin
                keep           = r_inside;
                o_cmd.byte0    = r_sum;
                o_cmd.byte1    = bsfe_pkg::BYTE_END;
                o_cmd.last_idx = 2'd1;
                o_cmd.is_end   = 1'b1;
                n_inside       = 1'b0;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum    <= 8'd0;
            r_inside <= 1'b0;
        end else if (o_push) begin
            r_sum    <= n_sum;
            r_inside <= n_inside;
        end
    end

endmodule

`default_nettype wire

// File: sv/bsfe_queue.sv
// ----------------------------------------------------------------------------
// bsfe_queue
// small command queue between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module bsfe_queue #(
    parameter int DEPTH = bsfe_pkg::QUEUE_DEPTH
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_push,
    input  bsfe_pkg::t_cmd  i_cmd,
    output logic            o_full,
    input  wire             i_pop,
    output logic            o_empty,
    output bsfe_pkg::t_cmd  o_head
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    bsfe_pkg::t_cmd r_mem [DEPTH];
    logic [AW-1:0]  r_wr_ptr;
    logic [AW-1:0]  r_rd_ptr;
    logic [CW-1:0]  r_count;

    function automatic logic [AW-1:0] ptr_next(input logic [AW-1:0] p);
        if (p == AW'(DEPTH - 1)) begin
            return '0;
        end
        return p + AW'(1);
    endfunction

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_next(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_next(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

`default_nettype wire

// File: sv/bsfe_back.sv
// ----------------------------------------------------------------------------
// bsfe_back
// serializes queued commands into line bytes through an output register
// ----------------------------------------------------------------------------
`default_nettype none

module bsfe_back (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_empty,
    input  bsfe_pkg::t_cmd     i_head,
    output logic               o_pop,
    output logic               o_out_valid,
    input  wire                i_out_ready,
    output bsfe_pkg::t_out_item o_out_data
);

    logic [1:0]          r_idx;
    logic                r_valid;
    bsfe_pkg::t_out_item r_out;
    logic                load;
    logic                last;
    logic [7:0]          sel_byte;

    assign load = !i_empty && (!r_valid || i_out_ready);
    assign last = (r_idx == i_head.last_idx);
    assign o_pop = load && last;

    always_comb begin
        unique case (r_idx)
            2'd0:    sel_byte = i_head.byte0;
            2'd1:    sel_byte = i_head.byte1;
            default: sel_byte = i_head.byte2;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 2'd0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= last ? 2'd0 : r_idx + 2'd1;
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out.line_byte  <= sel_byte;
            r_out.run_last   <= last;
            r_out.frame_done <= last && i_head.is_end;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// File: sv/byte_stuffed_frame_encoder_unit.sv
// ----------------------------------------------------------------------------
// byte_stuffed_frame_encoder_unit
// frame encoder with byte stuffing and an 8-bit additive checksum
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                 payload
//  in        input      i_in_valid / o_in_ready   i_in_data  (t_in_item)
//  out       output     o_out_valid / i_out_ready o_out_data (t_out_item)
//
//  one line byte per cycle leaves the output register while i_out_ready is
//  high; an item makes 1 to 3 line bytes there (start 3, escaped data 2,
//  plain data 1, end 2), set by the single byte lane of the back serializer
//  the front takes one transaction per cycle while the queue has room, so
//  dropped items and short items overlap with longer ones still draining
//  synchronous active-low reset empties the queue and closes any frame
//  a stall on the output only backs up the queue; the input stalls when full
// ----------------------------------------------------------------------------
`default_nettype none

module byte_stuffed_frame_encoder_unit #(
    parameter int QUEUE_DEPTH = bsfe_pkg::QUEUE_DEPTH
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    // input transactions
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  bsfe_pkg::t_in_item  i_in_data,
    // line byte transactions
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output bsfe_pkg::t_out_item o_out_data
);

    // front to queue
    logic           push;
    bsfe_pkg::t_cmd push_cmd;
    logic           queue_full;

    // queue to back
    logic           pop;
    logic           queue_empty;
    bsfe_pkg::t_cmd head_cmd;

    // front: classify, escape, keep the running checksum and frame state
    bsfe_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_cmd        (push_cmd)
    );

    // decoupling queue of classified commands
    bsfe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (queue_full),
        .i_pop   (pop),
        .o_empty (queue_empty),
        .o_head  (head_cmd)
    );

    // back: walk the bytes of the head command into the output register
    bsfe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (queue_empty),
        .i_head      (head_cmd),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for byte_stuffed_frame_encoder_unit: random frames and
// noise items are offered on the input channel, every accepted transaction is
// encoded by a bench-side model of the framer, and each line byte leaving
// the unit is compared in order against the predicted bytes
// ----------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    // op code that the unit must ignore
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // cycles without any transaction before the run is declared hung;
    // covers the forced receiver hold plus the longest random gap
    localparam int HANG_LIMIT  = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int HOLD_AT     = 100;   // line bytes seen before the hold
    localparam int DRAIN_WAIT  = 20;
    localparam int RAND_ITEMS  = 450;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_ready;
    bsfe_pkg::t_in_item  i_in_data = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    bsfe_pkg::t_out_item o_out_data;

    byte_stuffed_frame_encoder_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // items waiting to be offered, filled once by the stimulus block
    bsfe_pkg::t_in_item  item_q[$];
    // line bytes predicted but not yet seen on the output
    bsfe_pkg::t_out_item line_bytes_due[$];

    // bench copy of the framer state
    logic       frame_open = 1'b0;
    logic [7:0] frame_sum = '0;

    // bookkeeping
    int         err_cnt = 0;
    int         items_taken = 0;
    int         bytes_seen = 0;
    int         frames_closed = 0;
    int         escapes_seen = 0;
    int         idle_cycles = 0;
    logic       in_taken = 1'b0;

    // ------------------------------------------------------------------------
    // clock
    // ------------------------------------------------------------------------
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // helpers
    // ------------------------------------------------------------------------

    // gap length: mostly none or short, a few long; calm windows give none
    function automatic int idle_gap(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // byte with a strong bias towards the ones that need escaping
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 9))
            0: return bsfe_pkg::BYTE_START;
            1: return bsfe_pkg::BYTE_ESC;
            2: return bsfe_pkg::BYTE_END;
            3: return ($urandom_range(0, 1) != 0) ? 8'h00 : 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic bsfe_pkg::t_in_item mk_item(input logic [1:0] op,
                                                   input logic [7:0] kind,
                                                   input logic [7:0] seq,
                                                   input logic [7:0] data);
        bsfe_pkg::t_in_item it;
        it.op              = op;
        it.frame_kind      = kind;
        it.sequence_number = seq;
        it.data_byte       = data;
        return it;
    endfunction

    // unused fields carry random bits so every input bit toggles
    function automatic bsfe_pkg::t_in_item rnd_item(input logic [1:0] op);
        return mk_item(op, 8'($urandom), 8'($urandom), 8'($urandom));
    endfunction

    // appends one item to the stimulus list
    function automatic void add_item(input bsfe_pkg::t_in_item it);
        item_q.insert(item_q.size(), it);
    endfunction

    function automatic void push_line(input logic [7:0] b, input logic last,
                                      input logic done);
        line_bytes_due.insert(line_bytes_due.size(),
                              bsfe_pkg::t_out_item'{line_byte: b, run_last: last,
                                                    frame_done: done});
    endfunction

    // predicts the line bytes of one accepted transaction
    function automatic void encode_item(input bsfe_pkg::t_in_item it);
        logic [7:0] code;
        case (it.op)
            bsfe_pkg::OP_START: begin
                // a start always opens a fresh frame, even over an open one
                push_line(bsfe_pkg::BYTE_START, 1'b0, 1'b0);
                push_line(it.frame_kind, 1'b0, 1'b0);
                push_line(it.sequence_number, 1'b1, 1'b0);
                frame_sum  = it.frame_kind + it.sequence_number;
                frame_open = 1'b1;
            end
            bsfe_pkg::OP_DATA: begin
                if (frame_open) begin
                    if (it.data_byte == bsfe_pkg::BYTE_START)
                        code = bsfe_pkg::ESC_CODE_START;
                    else if (it.data_byte == bsfe_pkg::BYTE_ESC)
                        code = bsfe_pkg::ESC_CODE_ESC;
                    else if (it.data_byte == bsfe_pkg::BYTE_END)
                        code = bsfe_pkg::ESC_CODE_END;
                    else
                        code = '0;
                    if (code == '0) begin
                        push_line(it.data_byte, 1'b1, 1'b0);
                        frame_sum = frame_sum + it.data_byte;
                    end else begin
                        // escape pair, both bytes enter the checksum
                        push_line(bsfe_pkg::BYTE_ESC, 1'b0, 1'b0);
                        push_line(code, 1'b1, 1'b0);
                        frame_sum = frame_sum + bsfe_pkg::BYTE_ESC + code;
                        escapes_seen++;
                    end
                end
            end
            bsfe_pkg::OP_END: begin
                if (frame_open) begin
                    push_line(frame_sum, 1'b0, 1'b0);
                    push_line(bsfe_pkg::BYTE_END, 1'b1, 1'b1);
                    frame_open = 1'b0;
                    frames_closed++;
                end
            end
            default: begin
                // unused op, nothing happens
            end
        endcase
    endfunction

    function automatic void note_error(input string what,
                                       input bsfe_pkg::t_out_item want,
                                       input bsfe_pkg::t_out_item got);
        err_cnt++;
        if (err_cnt <= 10)
            $display("%t mismatch (%s): expected byte %h last %b done %b, %s",
                     $realtime, what, want.line_byte, want.run_last,
                     want.frame_done,
                     $sformatf("got byte %h last %b done %b",
                               got.line_byte, got.run_last, got.frame_done));
    endfunction

    // ------------------------------------------------------------------------
    // input driver: new transaction offered on the falling edge after the
    // previous one was accepted, with random gaps in between
    // ------------------------------------------------------------------------
    int tx_gap = 0;
    int tx_cnt = 0;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            if (tx_gap > 0) begin
                tx_gap--;
                i_in_valid <= 1'b0;
            end else if (item_q.size() > 0) begin
                i_in_data  <= item_q.pop_front();
                i_in_valid <= 1'b1;
                tx_cnt++;
                // calm stretch at the start of every 150 items
                tx_gap = idle_gap((tx_cnt % 150) < 40);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // output receiver: random back-pressure plus one long forced hold so the
    // internal queue fills and the input side has to stall
    // ------------------------------------------------------------------------
    int  rx_gap = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (!hold_done && bytes_seen >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            rx_gap = idle_gap((bytes_seen % 200) < 60);
        end
    end

    // ------------------------------------------------------------------------
    // monitor: predicts on input transactions, checks output transactions
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        bsfe_pkg::t_out_item want;
        in_taken <= i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                encode_item(i_in_data);
                items_taken++;
            end
            if (o_out_valid && i_out_ready) begin
                bytes_seen++;
                if (line_bytes_due.size() == 0) begin
                    note_error("unexpected line byte", '0, o_out_data);
                end else begin
                    want = line_bytes_due.pop_front();
                    if (o_out_data.line_byte !== want.line_byte)
                        note_error("line_byte", want, o_out_data);
                    else if (o_out_data.run_last !== want.run_last)
                        note_error("run_last", want, o_out_data);
                    else if (o_out_data.frame_done !== want.frame_done)
                        note_error("frame_done", want, o_out_data);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: cycles in which no transaction happens on either channel
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= HANG_LIMIT) begin
            $display("%t no transaction for %0d cycles, %0d line bytes still due",
                     $realtime, HANG_LIMIT, line_bytes_due.size());
            $display("*** FAILED ***");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus, reset and end of run
    // ------------------------------------------------------------------------
    initial begin
        int n_frame;
        int n_data;
        int r;

        // directed: drops outside a frame and the unused op
        add_item(rnd_item(bsfe_pkg::OP_END));
        add_item(mk_item(bsfe_pkg::OP_DATA, 8'h00, 8'h00, bsfe_pkg::BYTE_START));
        add_item(rnd_item(OP_UNUSED));
        // all-zero header, plain extremes, every escaped byte, neighbours
        add_item(mk_item(bsfe_pkg::OP_START, 8'h00, 8'h00, 8'hFF));
        add_item(mk_item(bsfe_pkg::OP_DATA, 8'hFF, 8'hFF, 8'h00));
        add_item(mk_item(bsfe_pkg::OP_DATA, 8'h00, 8'h00, 8'hFF));
        add_item(mk_item(bsfe_pkg::OP_DATA, 8'h00, 8'h00, bsfe_pkg::BYTE_START));
        add_item(mk_item(bsfe_pkg::OP_DATA, 8'h00, 8'h00, bsfe_pkg::BYTE_ESC));
        add_item(mk_item(bsfe_pkg::OP_DATA, 8'h00, 8'h00, bsfe_pkg::BYTE_END));
        add_item(mk_item(bsfe_pkg::OP_DATA, 8'h00, 8'h00, 8'h41));
        add_item(mk_item(bsfe_pkg::OP_DATA, 8'h00, 8'h00, 8'h7C));
        add_item(mk_item(bsfe_pkg::OP_END, 8'hFF, 8'hFF, 8'hFF));
        // all-ones header with a checksum that wraps, unused op inside a frame
        add_item(mk_item(bsfe_pkg::OP_START, 8'hFF, 8'hFF, 8'h00));
        add_item(mk_item(bsfe_pkg::OP_DATA, 8'h00, 8'h00, 8'h7A));
        add_item(mk_item(OP_UNUSED, 8'hFF, 8'hFF, 8'hFF));
        // restart over an open frame, header bytes that are never escaped
        add_item(mk_item(bsfe_pkg::OP_START, bsfe_pkg::BYTE_START, bsfe_pkg::BYTE_END,
                         bsfe_pkg::BYTE_ESC));
        add_item(mk_item(bsfe_pkg::OP_DATA, 8'h00, 8'h00, 8'h68));
        add_item(mk_item(bsfe_pkg::OP_DATA, 8'h00, 8'h00, 8'h80));
        add_item(mk_item(bsfe_pkg::OP_END, 8'h00, 8'h00, 8'h00));
        // end and data right after the frame closed are dropped
        add_item(rnd_item(bsfe_pkg::OP_END));
        add_item(rnd_item(bsfe_pkg::OP_DATA));
        // empty frame
        add_item(mk_item(bsfe_pkg::OP_START, 8'h01, 8'h80, 8'h00));
        add_item(rnd_item(bsfe_pkg::OP_END));

        // random: mostly well-formed frames, some noise and abandoned frames
        n_frame = 0;
        while (n_frame < RAND_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 15) begin
                // noise: any op, any fields
                add_item(rnd_item(2'($urandom_range(0, 3))));
            end else begin
                add_item(mk_item(bsfe_pkg::OP_START, pick_byte(), pick_byte(),
                                 8'($urandom)));
                n_frame++;
                n_data = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 30)
                                                     : $urandom_range(0, 8);
                repeat (n_data) begin
                    add_item(mk_item(bsfe_pkg::OP_DATA, 8'($urandom), 8'($urandom),
                                     pick_byte()));
                    n_frame++;
                    if ($urandom_range(0, 29) == 0)
                        add_item(rnd_item(OP_UNUSED));
                end
                // a few frames are left open and get restarted
                if (r >= 25) begin
                    add_item(rnd_item(bsfe_pkg::OP_END));
                    n_frame++;
                end
            end
        end

        // synchronous reset, released on a falling edge
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // all items accepted, then all line bytes out, then a short tail
        // to catch stray bytes
        @(posedge i_clk);
        while (item_q.size() != 0 || i_in_valid)
            @(posedge i_clk);
        while (line_bytes_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (line_bytes_due.size() != 0)
            err_cnt++;

        $display("run covered %0d input transactions and %0d line bytes",
                 items_taken, bytes_seen);
        $display("  %0d frames closed, %0d escape pairs, %0d errors",
                 frames_closed, escapes_seen, err_cnt);
        if (err_cnt == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// File: filelist.f
sv/bsfe_pkg.sv
sv/bsfe_front.sv
sv/bsfe_queue.sv
sv/bsfe_back.sv
sv/byte_stuffed_frame_encoder_unit.sv
tb/tb.sv
